[design/npcm_pkg.sv]
// Package for the nearest palette color matcher.
// Holds the entry layout, widths, mode codes and the channel distance helper.
// No dependencies.
package npcm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 255;
    localparam int CH_W                = 8;
    localparam int ENTRY_W             = 3 * CH_W;
    localparam int QUERY_W             = 6;
    localparam int DIST_W              = 10;

    // Larger than any L1 distance over three 8-bit channels (765).
    localparam logic [DIST_W-1:0] START_DISTANCE = 10'd1000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[design/nearest_palette_color_match.sv]
// A palette write never raises busy. A query holds busy while it scans the
// palette, one palette RAM read per entry plus one compare stage; o_done pulses
// in the same cycle that busy falls. An exact match at an entry ends the scan
// early. Reset clears a flag per entry, so every entry reads as zero until
// written; no clearing pass is needed and the block is ready at once.
module nearest_palette_color_match #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_mode,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_done,
    output logic [7:0] o_color_index
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0]                         r_state, n_state;
    logic                               r_issue, n_issue;
    logic [ADDR_W-1:0]                  r_addr, n_addr;
    logic                               r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]                  r_rd_idx;
    logic                               r_ent_valid;
    logic [npcm_pkg::DIST_W-1:0]        r_best_dist, n_best_dist;
    logic [ADDR_W-1:0]                  r_best_idx, n_best_idx;
    logic                               r_done, n_done;
    logic [7:0]                         r_color_index, n_color_index;
    logic [PALETTE_ENTRIES-1:0]         r_valid;
    npcm_pkg::t_rgb                     r_query;

    logic                               accept;
    logic                               in_range;
    logic                               wr_en;
    logic                               q_start;
    logic [npcm_pkg::ENTRY_W-1:0]       ram_rdata;
    npcm_pkg::t_rgb                     wr_entry;
    npcm_pkg::t_rgb                     ent;
    logic [npcm_pkg::DIST_W-1:0]        l1_dist;
    logic                               better;
    logic                               last;
    logic                               finish;
    logic [ADDR_W-1:0]                  cand_idx;

    assign accept   = start && !busy;
    assign in_range = {1'b0, i_entry_index} < 9'(PALETTE_ENTRIES);
    assign wr_en    = accept && (i_mode == npcm_pkg::MODE_WRITE) && in_range;
    assign q_start  = accept && (i_mode == npcm_pkg::MODE_QUERY);
    assign wr_entry = '{red: i_red, green: i_green, blue: i_blue};

    npcm_ram #(
        .WIDTH(npcm_pkg::ENTRY_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(i_entry_index[ADDR_W-1:0]),
        .i_wdata(wr_entry),
        .i_re   (r_issue),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // Compare stage: works on the entry read in the previous cycle.
    always_comb begin
        ent      = r_ent_valid ? npcm_pkg::t_rgb'(ram_rdata) : '0;
        l1_dist  = npcm_pkg::DIST_W'(npcm_pkg::abs_diff(r_query.red, ent.red))
                 + npcm_pkg::DIST_W'(npcm_pkg::abs_diff(r_query.green, ent.green))
                 + npcm_pkg::DIST_W'(npcm_pkg::abs_diff(r_query.blue, ent.blue));
        better   = l1_dist < r_best_dist;
        last     = r_rd_idx == LAST_ADDR;
        // An exact match is always also an improvement, so cand_idx covers both exits.
        finish   = r_rd_vld && ((l1_dist == '0) || last);
        cand_idx = better ? r_rd_idx : r_best_idx;
    end

    always_comb begin
        n_state       = r_state;
        n_issue       = r_issue;
        n_addr        = r_addr;
        n_rd_vld      = r_issue;
        n_best_dist   = r_best_dist;
        n_best_idx    = r_best_idx;
        n_done        = 1'b0;
        n_color_index = r_color_index;
        unique case (r_state)
            S_IDLE: begin
                if (q_start) begin
                    n_state     = S_SCAN;
                    n_issue     = 1'b1;
                    n_addr      = '0;
                    n_best_dist = npcm_pkg::START_DISTANCE;
                    n_best_idx  = '0;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_addr == LAST_ADDR) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_rd_vld && better) begin
                    n_best_dist = l1_dist;
                    n_best_idx  = r_rd_idx;
                end
                if (finish) begin
                    n_state       = S_IDLE;
                    n_issue       = 1'b0;
                    n_rd_vld      = 1'b0;
                    n_done        = 1'b1;
                    n_color_index = 8'(cand_idx);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
            if (wr_en) begin
                r_valid[i_entry_index[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_best_dist   <= n_best_dist;
        r_best_idx    <= n_best_idx;
        r_color_index <= n_color_index;
        if (r_issue) begin
            r_rd_idx    <= r_addr;
            r_ent_valid <= r_valid[r_addr];
        end
        if (q_start) begin
            r_query <= '{red:   {i_red[npcm_pkg::QUERY_W-1:0], 2'b00},
                         green: {i_green[npcm_pkg::QUERY_W-1:0], 2'b00},
                         blue:  {i_blue[npcm_pkg::QUERY_W-1:0], 2'b00}};
        end
    end

    assign busy          = (r_state == S_SCAN);
    assign o_done        = r_done;
    assign o_color_index = r_color_index;

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == npcm_pkg::MODE_QUERY)) |=> busy)
        else $error("query item did not start a scan");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == npcm_pkg::MODE_WRITE)) |=> (!busy && !o_done))
        else $error("write item started a scan or gave a result");

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside the end of a scan");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_color_index} < 9'(PALETTE_ENTRIES)))
        else $error("result index beyond the palette");

    a_compare_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_issue) |-> (r_state == S_SCAN))
        else $error("palette read in flight while idle");

endmodule

[design/npcm_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Depends on npcm_pkg for the default word width and depth.
module npcm_ram #(
    parameter int WIDTH = npcm_pkg::ENTRY_W,
    parameter int DEPTH = npcm_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
